[src/rtcc_pkg.sv]
// Shared types and constants for the tick-driven calendar counter.
package rtcc_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-1:0] ADDR_TICK_ENABLE = 3'd0;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_LOAD = 1'b1
  } mode_t;

  localparam logic [5:0] SEC_PER_MIN   = 6'd60;
  localparam logic [6:0] MIN_PER_HOUR  = 7'd60;
  localparam logic [5:0] SEC_LAST      = 6'd59;
  localparam logic [5:0] MIN_LAST      = 6'd59;
  localparam logic [5:0] HOURS_PER_DAY = 6'd24;
  localparam logic [2:0] DAYS_PER_WEEK = 3'd7;
  localparam logic [4:0] MONTHS_PER_YEAR = 5'd12;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  localparam logic [4:0] LEN_SHORT    = 5'd30;
  localparam logic [4:0] LEN_LONG     = 5'd31;
  localparam logic [4:0] LEN_FEB      = 5'd28;
  localparam logic [4:0] LEN_FEB_LEAP = 5'd29;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] date;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } load_t;

  // hour keeps one extra bit so loaded times up to hour 32 still roll the day
  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] date;
    logic [2:0] weekday;
    logic [5:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_t;

  localparam cal_t CAL_RESET = '{
    year: 8'd0, month: 4'd1, date: 5'd1, weekday: 3'd1,
    hour: 6'd0, minute: 6'd0, second: 6'd0
  };

endpackage

[src/tick_driven_calendar_counter.sv]
// Top level of the tick-driven calendar counter: input register, calendar state, result register.
//
//   channel  handshake            payload
//   req      req_valid/req_stall  mode, load_year .. load_second
//   rsp      rsp_valid/rsp_stall  second, minute, hour, weekday, date, month, year
//   cfg      APB psel/penable     tick_enable at byte address 0
//
// One beat per cycle unless stalled; a beat passes the input register, then the result register.
// The calendar state updates in the cycle a beat leaves the input register.
// req_stall rises only while the input register is full and the result is stalled.
// Reset clears the calendar to 00:00:00, weekday 1, 1 January, year 0, ticks disabled.
module tick_driven_calendar_counter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        mode,
  input  logic [7:0]                  load_year,
  input  logic [3:0]                  load_month,
  input  logic [4:0]                  load_date,
  input  logic [2:0]                  load_weekday,
  input  logic [4:0]                  load_hour,
  input  logic [5:0]                  load_minute,
  input  logic [5:0]                  load_second,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [5:0]                  second,
  output logic [5:0]                  minute,
  output logic [4:0]                  hour,
  output logic [2:0]                  weekday,
  output logic [4:0]                  date,
  output logic [3:0]                  month,
  output logic [7:0]                  year,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rtcc_pkg::ADDR_W-1:0] paddr,
  input  logic [rtcc_pkg::DATA_W-1:0] pwdata,
  output logic [rtcc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  logic            tick_enable;
  logic            in_vld;
  rtcc_pkg::mode_t in_mode;
  rtcc_pkg::load_t in_load;
  rtcc_pkg::cal_t  cal;
  rtcc_pkg::cal_t  cal_next;
  rtcc_pkg::cal_t  out_cal;
  logic            adv_out;
  logic            accept;

  rtcc_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .tick_enable (tick_enable)
  );

  rtcc_step u_step (
    .cal         (cal),
    .tick_enable (tick_enable),
    .mode        (in_mode),
    .load        (in_load),
    .cal_next    (cal_next)
  );

  assign adv_out   = !rsp_valid || !rsp_stall;
  assign req_stall = in_vld && !adv_out;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (adv_out) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_mode         <= rtcc_pkg::mode_t'(mode);
      in_load.year    <= load_year;
      in_load.month   <= load_month;
      in_load.date    <= load_date;
      in_load.weekday <= load_weekday;
      in_load.hour    <= load_hour;
      in_load.minute  <= load_minute;
      in_load.second  <= load_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal       <= rtcc_pkg::CAL_RESET;
      rsp_valid <= 1'b0;
    end else if (adv_out) begin
      rsp_valid <= in_vld;
      if (in_vld) begin
        cal <= cal_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && in_vld) begin
      out_cal <= cal_next;
    end
  end

  assign second  = out_cal.second;
  assign minute  = out_cal.minute;
  assign hour    = out_cal.hour[4:0];
  assign weekday = out_cal.weekday;
  assign date    = out_cal.date;
  assign month   = out_cal.month;
  assign year    = out_cal.year;

endmodule

[src/rtcc_cfg.sv]
// APB register block holding the tick enable.
module rtcc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rtcc_pkg::ADDR_W-1:0]      paddr,
  input  logic [rtcc_pkg::DATA_W-1:0]      pwdata,
  output logic [rtcc_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  output logic                             tick_enable
);

  logic sel_tick_enable;

  assign sel_tick_enable =
    (paddr[rtcc_pkg::ADDR_W-1:2] == rtcc_pkg::ADDR_TICK_ENABLE[rtcc_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && sel_tick_enable) begin
      tick_enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_tick_enable) begin
      prdata[0] = tick_enable;
    end
  end

endmodule

[src/rtcc_step.sv]
// Next-state logic for one beat: load with normalization, or tick with day rollover.
module rtcc_step (
  input  rtcc_pkg::cal_t  cal,
  input  logic            tick_enable,
  input  rtcc_pkg::mode_t mode,
  input  rtcc_pkg::load_t load,
  output rtcc_pkg::cal_t  cal_next
);

  logic       ld_sec_carry;
  logic [5:0] ld_sec;
  logic [6:0] ld_min_sum;
  logic       ld_min_carry;
  logic [5:0] ld_min;
  logic [5:0] ld_hour;

  logic       sec_carry;
  logic       min_carry;
  logic [5:0] t_sec;
  logic [5:0] t_min;
  logic [5:0] t_hour;
  logic       new_day;

  logic [4:0] month_len;
  logic       date_roll;
  logic [4:0] month_inc;
  logic       month_wrap;
  logic [2:0] wd_next;

  always_comb begin
    ld_sec_carry = (load.second >= rtcc_pkg::SEC_PER_MIN);
    ld_sec       = ld_sec_carry ? (load.second - rtcc_pkg::SEC_PER_MIN) : load.second;
    ld_min_sum   = {1'b0, load.minute} + {6'd0, ld_sec_carry};
    ld_min_carry = (ld_min_sum >= rtcc_pkg::MIN_PER_HOUR);
    ld_min       = ld_min_carry ? 6'(ld_min_sum - rtcc_pkg::MIN_PER_HOUR) : ld_min_sum[5:0];
    ld_hour      = {1'b0, load.hour} + {5'd0, ld_min_carry};
  end

  always_comb begin
    sec_carry = tick_enable && (cal.second == rtcc_pkg::SEC_LAST);
    min_carry = sec_carry && (cal.minute == rtcc_pkg::MIN_LAST);
    t_sec     = !tick_enable ? cal.second : (sec_carry ? 6'd0 : cal.second + 6'd1);
    t_min     = min_carry ? 6'd0 : (sec_carry ? cal.minute + 6'd1 : cal.minute);
    t_hour    = min_carry ? cal.hour + 6'd1 : cal.hour;
    new_day   = (t_hour >= rtcc_pkg::HOURS_PER_DAY);
  end

  always_comb begin
    unique case (cal.month)
      rtcc_pkg::MONTH_APR, rtcc_pkg::MONTH_JUN,
      rtcc_pkg::MONTH_SEP, rtcc_pkg::MONTH_NOV: month_len = rtcc_pkg::LEN_SHORT;
      rtcc_pkg::MONTH_FEB: month_len = (cal.year[1:0] == 2'd0) ?
                                       rtcc_pkg::LEN_FEB_LEAP : rtcc_pkg::LEN_FEB;
      default: month_len = rtcc_pkg::LEN_LONG;
    endcase
    date_roll  = (cal.date >= month_len);
    month_inc  = {1'b0, cal.month} + {4'd0, date_roll};
    month_wrap = (month_inc > rtcc_pkg::MONTHS_PER_YEAR);
    wd_next    = (cal.weekday == rtcc_pkg::DAYS_PER_WEEK) ? 3'd1 : cal.weekday + 3'd1;
  end

  always_comb begin
    cal_next = cal;
    unique case (mode)
      rtcc_pkg::MODE_LOAD: begin
        cal_next.year    = load.year;
        cal_next.month   = load.month;
        cal_next.date    = load.date;
        cal_next.weekday = load.weekday;
        cal_next.hour    = ld_hour;
        cal_next.minute  = ld_min;
        cal_next.second  = ld_sec;
      end
      rtcc_pkg::MODE_TICK: begin
        if (new_day) begin
          cal_next.hour    = 6'd0;
          cal_next.minute  = 6'd0;
          cal_next.second  = 6'd0;
          cal_next.weekday = wd_next;
          cal_next.date    = date_roll ? 5'd1 : cal.date + 5'd1;
          cal_next.month   = month_wrap ? 4'd1 : month_inc[3:0];
          cal_next.year    = month_wrap ? cal.year + 8'd1 : cal.year;
        end else begin
          cal_next.hour    = t_hour;
          cal_next.minute  = t_min;
          cal_next.second  = t_sec;
        end
      end
      default: cal_next = cal;
    endcase
  end

endmodule

[src/rtcc_checker.sv]
// Port-level assertions for the tick-driven calendar counter, bound to the top level.
module rtcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic [5:0] second,
  input logic [5:0] minute,
  input logic [4:0] hour,
  input logic [2:0] weekday,
  input logic [4:0] date,
  input logic [3:0] month,
  input logic [7:0] year
);

  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result beat shown right after reset");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (second < 6'd60) && (minute < 6'd60))
    else $error("second or minute out of range");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |-> ##2 rsp_valid)
    else $error("accepted beat produced no result in time");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid &&
      $stable({second, minute, hour, weekday, date, month, year}))
    else $error("stalled result beat changed");

endmodule

bind tick_driven_calendar_counter rtcc_checker u_rtcc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .second    (second),
  .minute    (minute),
  .hour      (hour),
  .weekday   (weekday),
  .date      (date),
  .month     (month),
  .year      (year)
);

[test/tb_top.sv]
// Testbench for the tick-driven calendar counter: directed and random beats checked against a model.
module tb_top;
  import rtcc_pkg::*;

  localparam int SECS_PER_DAY = 86400;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    mode_t mode;
    load_t ld;
  } req_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] date;
    logic [3:0] month;
    logic [7:0] year;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic mode = 1'b0;
  logic [7:0] load_year = '0;
  logic [3:0] load_month = '0;
  logic [4:0] load_date = '0;
  logic [2:0] load_weekday = '0;
  logic [4:0] load_hour = '0;
  logic [5:0] load_minute = '0;
  logic [5:0] load_second = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [2:0] weekday;
  logic [4:0] date;
  logic [3:0] month;
  logic [7:0] year;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  tick_driven_calendar_counter u_top (.*);

  logic ticks_on = 1'b0;
  int unsigned day_secs = 0;
  int unsigned wday = 1;
  int unsigned mday = 1;
  int unsigned mon = 1;
  int unsigned yr = 0;

  req_t req_q[$];
  reading_t cal_due[$];
  req_t cur_req;
  int reqs_sent = 0;
  int reqs_taken = 0;
  int mismatches = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) return LEN_SHORT;
    if (m == MONTH_FEB) return (y % 4 == 0) ? LEN_FEB_LEAP : LEN_FEB;
    return LEN_LONG;
  endfunction

  function automatic reading_t step_calendar(req_t r);
    int unsigned len;
    reading_t o;
    if (r.mode == MODE_LOAD) begin
      yr = r.ld.year;
      mon = r.ld.month;
      mday = r.ld.date;
      wday = r.ld.weekday;
      day_secs = int'(r.ld.second) + 60 * int'(r.ld.minute) + 3600 * int'(r.ld.hour);
    end else begin
      if (ticks_on) day_secs++;
      if (day_secs >= SECS_PER_DAY) begin
        len = days_in_month(mon, yr);
        day_secs = 0;
        wday = wday % DAYS_PER_WEEK + 1;
        if (mday >= len) begin
          mday = 1;
          mon++;
        end else begin
          mday++;
        end
        if (mon > MONTHS_PER_YEAR) begin
          mon = 1;
          yr = (yr + 1) % 256;
        end
      end
    end
    o.second = 6'(day_secs % 60);
    o.minute = 6'((day_secs % 3600) / 60);
    o.hour = 5'(day_secs / 3600);
    o.weekday = 3'(wday);
    o.date = 5'(mday);
    o.month = 4'(mon);
    o.year = 8'(yr);
    return o;
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t make_tick();
    req_t r;
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    r.ld = bits[$bits(load_t)-1:0];
    r.mode = MODE_TICK;
    return r;
  endfunction

  function automatic req_t make_load(int y, int m, int d, int w, int h, int mi, int s);
    req_t r;
    r.mode = MODE_LOAD;
    r.ld.year = 8'(y);
    r.ld.month = 4'(m);
    r.ld.date = 5'(d);
    r.ld.weekday = 3'(w);
    r.ld.hour = 5'(h);
    r.ld.minute = 6'(mi);
    r.ld.second = 6'(s);
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r = make_tick();
    if (pick >= 97) begin
      r.mode = MODE_LOAD;
    end else if (pick >= 92) begin
      r = make_load($urandom_range(0, 255), $urandom_range(1, 12), $urandom_range(1, 31),
                    $urandom_range(1, 7), $urandom_range(0, 23), $urandom_range(0, 59),
                    $urandom_range(0, 59));
    end else if (pick >= 82) begin
      r = make_load($urandom_range(0, 255), $urandom_range(1, 12), $urandom_range(27, 31),
                    $urandom_range(1, 7), 23, 59, $urandom_range(52, 59));
    end
    return r;
  endfunction

  task automatic queue_req(req_t r);
    req_q.push_back(r);
    reqs_sent++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PRINT_CAP) $display("%0t: %s got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic cfg_write(logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TICK_ENABLE;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ticks_on = value[0];
  endtask

  task automatic drain();
    while (reqs_taken != reqs_sent || cal_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_req
    bit busy;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      busy = req_valid;
      if (req_valid && !req_stall) begin
        cal_due.push_back(step_calendar(cur_req));
        reqs_taken++;
        busy = 1'b0;
        if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          mode <= cur_req.mode;
          load_year <= cur_req.ld.year;
          load_month <= cur_req.ld.month;
          load_date <= cur_req.ld.date;
          load_weekday <= cur_req.ld.weekday;
          load_hour <= cur_req.ld.hour;
          load_minute <= cur_req.ld.minute;
          load_second <= cur_req.ld.second;
          req_valid <= 1'b1;
          gap_left = send_calm ? 0 : pick_idle();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_rsp
    reading_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (cal_due.size() == 0) begin
          report_mismatch("beat with nothing due", 0, 0);
        end else begin
          want = cal_due.pop_front();
          if (second !== want.second) report_mismatch("second", second, want.second);
          if (minute !== want.minute) report_mismatch("minute", minute, want.minute);
          if (hour !== want.hour) report_mismatch("hour", hour, want.hour);
          if (weekday !== want.weekday) report_mismatch("weekday", weekday, want.weekday);
          if (date !== want.date) report_mismatch("date", date, want.date);
          if (month !== want.month) report_mismatch("month", month, want.month);
          if (year !== want.year) report_mismatch("year", year, want.year);
        end
        if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        if (!recv_calm && $urandom_range(0, 3) == 0) stall_left = pick_idle();
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    cfg_write(0);
    queue_req(make_tick());
    queue_req(make_load(255, 12, 31, 7, 23, 59, 59));
    queue_req(make_tick());
    queue_req(make_load(0, 1, 1, 1, 24, 0, 0));
    queue_req(make_tick());
    queue_req(make_load(255, 15, 31, 0, 31, 63, 63));
    queue_req(make_tick());
    queue_req(make_load(0, 0, 0, 0, 0, 0, 0));
    queue_req(make_tick());
    drain();

    cfg_write(1);
    queue_req(make_load(255, 12, 31, 7, 23, 59, 59));
    queue_req(make_tick());
    queue_req(make_load(4, 2, 28, 3, 23, 59, 59));
    queue_req(make_tick());
    queue_req(make_load(5, 2, 28, 3, 23, 59, 59));
    queue_req(make_tick());
    queue_req(make_load(8, 2, 29, 6, 23, 59, 59));
    queue_req(make_tick());
    queue_req(make_load(1, 4, 30, 0, 23, 59, 59));
    queue_req(make_tick());
    queue_req(make_load(2, 13, 5, 5, 23, 59, 59));
    queue_req(make_tick());
    queue_req(make_load(3, 0, 0, 2, 23, 59, 59));
    queue_req(make_tick());
    queue_req(make_load(7, 6, 15, 4, 0, 59, 59));
    queue_req(make_tick());
    drain();

    repeat (1200) queue_req(rand_req());
    drain();

    cfg_write(0);
    repeat (300) queue_req(rand_req());
    drain();

    cfg_write(1);
    repeat (400) queue_req(rand_req());
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[tick_driven_calendar_counter.f]
src/rtcc_pkg.sv
src/rtcc_cfg.sv
src/rtcc_step.sv
src/tick_driven_calendar_counter.sv
src/rtcc_checker.sv
test/tb_top.sv
